// ===== rtl/starenv_pkg.sv =====
// ----------------------------------------------------------------------------
// starenv_pkg
// Shared types and constants for the sine tone generator with an
// attack and release envelope.
// ----------------------------------------------------------------------------
`default_nettype none

package starenv_pkg;

    localparam int PHASE_BITS_DEF          = 32;
    localparam int COUNT_BITS_DEF          = 24;
    localparam int QUARTER_TABLE_DEPTH_DEF = 256;
    localparam int SAMPLE_BITS_DEF         = 16;

    localparam int ENV_BITS     = 16;
    localparam int LEVEL_BITS   = 16;
    localparam int CFG_IDX_BITS = 1;

    localparam logic [ENV_BITS-1:0]   ATTACK_RESET  = 16'd240;
    localparam logic [ENV_BITS-1:0]   RELEASE_RESET = 16'd2400;
    localparam logic [ENV_BITS-1:0]   ENV_FULL      = 16'hFFFF;
    localparam logic [LEVEL_BITS-1:0] LEVEL_FULL    = 16'h8000;

    localparam logic OP_TICK    = 1'b0;
    localparam logic OP_TRIGGER = 1'b1;

    localparam logic [CFG_IDX_BITS-1:0] CFG_ATTACK  = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RELEASE = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL1,
        S_DIV,
        S_MUL2,
        S_DONE
    } t_state;

    typedef struct packed {
        logic                busy;
        logic [ENV_BITS-1:0] quot;
    } t_div_rsp;

endpackage

`default_nettype wire

// ===== rtl/starenv_sine_rom.sv =====
// ----------------------------------------------------------------------------
// starenv_sine_rom
// Quarter-wave sine magnitude table in Q1.15 with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module starenv_sine_rom #(
    parameter int QUARTER_TABLE_DEPTH = starenv_pkg::QUARTER_TABLE_DEPTH_DEF
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_en,
    input  wire logic [$clog2(QUARTER_TABLE_DEPTH)-1:0] i_addr,
    output logic      [15:0]                            o_data
);
    import starenv_pkg::*;

    localparam int LOG_DEPTH = $clog2(QUARTER_TABLE_DEPTH);
    localparam logic [63:0] PI_Q30  = 64'd3373259426;
    localparam logic [63:0] ONE_Q30 = 64'd1073741824;

    function automatic logic [63:0] next_term(logic [63:0] term, logic [63:0] x);
        logic [63:0] t;
        t = (term * x) >> 30;
        t = (t * x) >> 30;
        return t;
    endfunction

    function automatic logic [15:0] quarter_sine(logic [63:0] i);
        logic [63:0] x;
        logic [63:0] t1, t2, t3, t4, t5, t6, t7;
        logic signed [63:0] sum;
        logic [63:0] scaled;
        x  = (PI_Q30 * (2 * i + 64'd1)) >> (LOG_DEPTH + 2);
        t1 = x;
        t2 = next_term(t1, x) / 64'd6;
        t3 = next_term(t2, x) / 64'd20;
        t4 = next_term(t3, x) / 64'd42;
        t5 = next_term(t4, x) / 64'd72;
        t6 = next_term(t5, x) / 64'd110;
        t7 = next_term(t6, x) / 64'd156;
        sum = $signed(t1) - $signed(t2) + $signed(t3) - $signed(t4)
            + $signed(t5) - $signed(t6) + $signed(t7);
        if (sum < 0) begin
            sum = 0;
        end
        if (sum > $signed(ONE_Q30)) begin
            sum = $signed(ONE_Q30);
        end
        scaled = ($unsigned(sum) * 64'd32767) >> 30;
        return scaled[15:0];
    endfunction

    logic [15:0] w_rom [QUARTER_TABLE_DEPTH];
    logic [15:0] r_data;

    for (genvar g = 0; g < QUARTER_TABLE_DEPTH; g++) begin : g_rom
        assign w_rom[g] = quarter_sine(64'(g));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= w_rom[i_addr];
        end
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

// ===== rtl/starenv_div.sv =====
// ----------------------------------------------------------------------------
// starenv_div
// Restoring divider for the envelope ramp. It forms
// floor(num * 2^16 / den) for num < den, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module starenv_div (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_start,
    input  wire logic [starenv_pkg::ENV_BITS-1:0] i_num,
    input  wire logic [starenv_pkg::ENV_BITS-1:0] i_den,
    output starenv_pkg::t_div_rsp                 o_rsp
);
    import starenv_pkg::*;

    localparam int CNT_BITS = $clog2(ENV_BITS + 1);

    logic                  r_busy;
    logic [CNT_BITS-1:0]   r_cnt;
    logic [ENV_BITS:0]     r_rem;
    logic [ENV_BITS-1:0]   r_den;
    logic [ENV_BITS-1:0]   r_quot;

    logic [ENV_BITS:0]     w_shift;
    logic                  w_ge;
    logic [ENV_BITS:0]     n_rem;

    always_comb begin
        w_shift = {r_rem[ENV_BITS-1:0], 1'b0};
        w_ge    = (w_shift >= {1'b0, r_den});
        n_rem   = w_ge ? (w_shift - {1'b0, r_den}) : w_shift;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_BITS'(ENV_BITS);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_BITS'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= {1'b0, i_num};
            r_den  <= i_den;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= n_rem;
            r_quot <= {r_quot[ENV_BITS-2:0], w_ge};
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.quot = r_quot;

endmodule

`default_nettype wire

// ===== rtl/sine_tone_with_ar_envelope.sv =====
// ----------------------------------------------------------------------------
// sine_tone_with_ar_envelope
// Tone generator: phase accumulator, quarter-wave sine table, peak level
// and a linear attack and release envelope, on one shared multiplier.
//
//   Channel  Direction  Handshake                 Payload
//   in       input      i_in_valid / o_in_stall   op, phase_step, tone_length,
//                                                 tone_level
//   out      output     o_out_valid / i_out_stall sample, active
//   cfg      input      i_cfg_we                  i_cfg_idx, i_cfg_data
//
// A trigger transfer gives no result. A tick that plays a sample goes through
// S_MUL1, S_DIV, S_MUL2 and S_DONE, waiting in S_DIV for the envelope divider
// only inside a ramp. A tick while idle goes straight to S_DONE with a zero
// sample. A stalled output adds the cycles that the result waits to enter the
// output register. Synchronous reset clears the sequencer, the tone state and
// the output valid flag and presets the attack and release lengths. A result
// waits in the output register while the next item is already taken in.
// ----------------------------------------------------------------------------
`default_nettype none

module sine_tone_with_ar_envelope #(
    parameter int PHASE_BITS          = starenv_pkg::PHASE_BITS_DEF,
    parameter int COUNT_BITS          = starenv_pkg::COUNT_BITS_DEF,
    parameter int QUARTER_TABLE_DEPTH = starenv_pkg::QUARTER_TABLE_DEPTH_DEF,
    parameter int SAMPLE_BITS         = starenv_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_cfg_we,
    input  wire logic [starenv_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  wire logic [starenv_pkg::ENV_BITS-1:0]       i_cfg_data,
    input  wire logic                                   i_in_valid,
    output logic                                        o_in_stall,
    input  wire logic                                   i_op,
    input  wire logic [PHASE_BITS-1:0]                  i_phase_step,
    input  wire logic [COUNT_BITS-1:0]                  i_tone_length,
    input  wire logic [starenv_pkg::LEVEL_BITS-1:0]     i_tone_level,
    output logic                                        o_out_valid,
    input  wire logic                                   i_out_stall,
    output logic signed [SAMPLE_BITS-1:0]               o_sample,
    output logic                                        o_active
);
    import starenv_pkg::*;

    localparam int LOG_DEPTH = $clog2(QUARTER_TABLE_DEPTH);
    localparam int CW        = ((COUNT_BITS > ENV_BITS) ? COUNT_BITS : ENV_BITS) + 1;
    localparam int SW        = SAMPLE_BITS + 16;
    localparam int SHL       = (SAMPLE_BITS >= 16) ? SAMPLE_BITS - 16 : 0;
    localparam int SHR       = (SAMPLE_BITS >= 16) ? 0 : 16 - SAMPLE_BITS;
    localparam logic [SW-1:0] W_LIM = SW'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);

    t_state r_state, n_state;

    logic [ENV_BITS-1:0]    r_attack;
    logic [ENV_BITS-1:0]    r_release;
    logic [PHASE_BITS-1:0]  r_phase;
    logic [PHASE_BITS-1:0]  r_step;
    logic [COUNT_BITS-1:0]  r_count;
    logic [COUNT_BITS-1:0]  r_length;
    logic [LEVEL_BITS-1:0]  r_level;
    logic                   r_playing;
    logic                   r_neg;
    logic                   r_need_div;
    logic [15:0]            r_mag;
    logic [SAMPLE_BITS-1:0] r_res_sample;
    logic                   r_res_active;
    logic                   r_out_valid;
    logic [SAMPLE_BITS-1:0] r_out_sample;
    logic                   r_out_active;

    logic                   w_accept;
    logic                   w_tick;
    logic                   w_trigger;
    logic                   w_play;
    logic                   w_out_free;
    logic                   w_load_out;

    logic [COUNT_BITS-1:0]  w_count_inc;
    logic                   w_in_attack;
    logic                   w_in_release;
    logic [ENV_BITS-1:0]    w_div_num;
    logic [ENV_BITS-1:0]    w_div_den;
    logic [LEVEL_BITS-1:0]  w_level_sat;

    logic [PHASE_BITS-3:0]  w_frac;
    logic [LOG_DEPTH-1:0]   w_idx;
    logic [15:0]            w_sine;
    t_div_rsp               w_div;

    logic [15:0]            w_mul_a;
    logic [15:0]            w_mul_b;
    logic [31:0]            w_prod;
    logic [15:0]            w_env;
    logic [SW-1:0]          w_wide;
    logic [SW-1:0]          w_sat;
    logic [SAMPLE_BITS-1:0] w_final;

    // Table address from the current phase, mirrored in odd quadrants.
    always_comb begin
        w_frac = r_phase[PHASE_BITS-3:0];
        w_idx  = w_frac[PHASE_BITS-3 -: LOG_DEPTH];
        if (r_phase[PHASE_BITS-2]) begin
            w_idx = ~w_idx;
        end
    end

    starenv_sine_rom #(
        .QUARTER_TABLE_DEPTH(QUARTER_TABLE_DEPTH)
    ) u_rom (
        .i_clk  (i_clk),
        .i_en   (w_accept),
        .i_addr (w_idx),
        .o_data (w_sine)
    );

    always_comb begin
        w_count_inc  = r_count + 1'b1;
        w_in_attack  = (CW'(r_count) < CW'(r_attack));
        w_in_release = (r_release != '0)
                     && ((CW'(r_count) + CW'(r_release)) > CW'(r_length));
        if (w_in_attack) begin
            w_div_num = ENV_BITS'(r_count);
            w_div_den = r_attack;
        end else begin
            w_div_num = ENV_BITS'(r_length - r_count);
            w_div_den = r_release;
        end
        w_level_sat = (i_tone_level > LEVEL_FULL) ? LEVEL_FULL : i_tone_level;
    end

    starenv_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_tick && w_play && (w_in_attack || w_in_release)),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_rsp   (w_div)
    );

    // Shared multiplier: sine times level, then magnitude times envelope.
    always_comb begin
        w_env = r_need_div ? w_div.quot : ENV_FULL;
        if (r_state == S_MUL1) begin
            w_mul_a = w_sine;
            w_mul_b = r_level;
        end else begin
            w_mul_a = r_mag;
            w_mul_b = w_env;
        end
        w_prod  = w_mul_a * w_mul_b;
        w_wide  = (SW'(w_prod[31:16]) << SHL) >> SHR;
        w_sat   = (w_wide > W_LIM) ? W_LIM : w_wide;
        w_final = r_neg ? SAMPLE_BITS'(-w_sat) : SAMPLE_BITS'(w_sat);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_tick) begin
                    n_state = w_play ? S_MUL1 : S_DONE;
                end
            end
            S_MUL1: n_state = S_DIV;
            S_DIV: begin
                if (!w_div.busy) begin
                    n_state = S_MUL2;
                end
            end
            S_MUL2: n_state = S_DONE;
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall = (r_state != S_IDLE);
        w_accept   = i_in_valid && (r_state == S_IDLE);
        w_trigger  = w_accept && (i_op == OP_TRIGGER);
        w_tick     = w_accept && (i_op == OP_TICK);
        w_play     = r_playing && (r_count < r_length);
        w_out_free = !r_out_valid || !i_out_stall;
        w_load_out = (r_state == S_DONE) && w_out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_attack  <= ATTACK_RESET;
            r_release <= RELEASE_RESET;
            r_phase   <= '0;
            r_step    <= '0;
            r_count   <= '0;
            r_length  <= '0;
            r_level   <= '0;
            r_playing <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ATTACK:  r_attack  <= i_cfg_data;
                    CFG_RELEASE: r_release <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_trigger) begin
                r_step    <= i_phase_step;
                r_length  <= i_tone_length;
                r_level   <= w_level_sat;
                r_phase   <= '0;
                r_count   <= '0;
                r_playing <= 1'b1;
            end else if (w_tick) begin
                if (w_play) begin
                    r_phase   <= r_phase + r_step;
                    r_count   <= w_count_inc;
                    r_playing <= (w_count_inc < r_length);
                end else begin
                    r_playing <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_tick) begin
            r_neg        <= r_phase[PHASE_BITS-1];
            r_need_div   <= w_in_attack || w_in_release;
            r_res_sample <= '0;
            r_res_active <= w_play && (w_count_inc < r_length);
        end
        if (r_state == S_MUL1) begin
            r_mag <= w_prod[30:15];
        end
        if (r_state == S_MUL2) begin
            r_res_sample <= w_final;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_sample <= r_res_sample;
            r_out_active <= r_res_active;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_sample    = $signed(r_out_sample);
    assign o_active    = r_out_active;

endmodule

`default_nettype wire
